// ----- rtl/set_assoc_lru_cache_prefetch_assert.svh -----
// assertion macros for the set associative cache block
`ifndef SET_ASSOC_LRU_CACHE_PREFETCH_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_PREFETCH_ASSERT_SVH

// condition implies consequence in the same cycle
`define SALCP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SALCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/salcp_pkg.sv -----
// shared types and constants of the set associative cache block
`default_nettype none

package salcp_pkg;

  localparam int ADDR_IN_W = 48;
  localparam int CNT_W = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 4;

  localparam int DEF_MAX_SETS = 256;
  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_ADDR_WIDTH = 48;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_ON = 4'd3;

  localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [3:0] RST_SET_BITS = 4'd8;
  localparam logic [3:0] RST_WAYS_USED = 4'd8;
  localparam logic RST_PREFETCH_ON = 1'b0;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic op;
    logic [ADDR_IN_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic was_hit;
    logic prefetch_filled;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] write_total;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/set_assoc_lru_cache_prefetch.sv -----
// set associative lru cache model with write-through counting and next-line prefetch
`default_nettype none
`include "set_assoc_lru_cache_prefetch_assert.svh"

// Usage
//   Input: an access (op, address) transfers on a clock edge with start high and
//   busy low. Configuration writes use cfg_valid/cfg_ready with a register index
//   and 4 bits of data; cfg_ready is always high, and writes belong to idle time.
//   Output: one result per access, shown for one cycle with out_valid high.
//   The receiver cannot stall; every result is taken in the cycle it shows.
// Access steps
//   An access is accepted, its set row is read, and the updated row is written
//   back in the following cycle. A demand miss with prefetch on reads and
//   writes the next block's set as well, in a second lookup step, since the
//   set memory has a single read port.
//   The result appears in the cycle after the last write back, while the next
//   access may already be accepted.
// Reset
//   rst_n low clears the counters and loads the reset configuration. After
//   release a clearing pass invalidates every set row, one row a cycle; busy
//   stays high during it, configuration writes are still taken.

module set_assoc_lru_cache_prefetch #(
  parameter int MAX_SETS = salcp_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salcp_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = salcp_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire salcp_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  output salcp_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [salcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [salcp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = ADDR_WIDTH;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int CW = salcp_pkg::CNT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  localparam logic [2:0] ST_CLR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LK1 = 3'd2;
  localparam logic [2:0] ST_LK2 = 3'd3;

  typedef struct packed {
    logic [MAX_WAYS-1:0] valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0][AW-1:0] tag;
  } row_t;

  // set memory
  row_t mem [MAX_SETS];
  row_t rdata_r;
  logic rd_en;
  logic [SET_W-1:0] rd_addr;
  logic wr_en;
  logic [SET_W-1:0] wr_addr;
  row_t wr_row;

  // control and config
  logic [2:0] state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [3:0] offset_bits_r, set_bits_r, ways_used_r;
  logic prefetch_on_r;
  logic out_valid_r, out_valid_nxt;
  logic [CW-1:0] hits_r, hits_nxt, misses_r, misses_nxt;
  logic [CW-1:0] reads_r, reads_nxt, writes_r, writes_nxt;

  // item payload
  logic op_r;
  logic [AW-1:0] addr_r, naddr_r;
  logic [SET_W-1:0] set_r;
  logic was_hit_r, was_hit_nxt;
  logic pf_fill_r, pf_fill_nxt;
  row_t wb_row_r;

  // address split
  logic [3:0] sb_eff;
  logic [4:0] ways_eff;
  logic [MAX_WAYS-1:0] way_en;
  logic [AW-1:0] smask;
  logic [4:0] tag_shift;
  logic [AW-1:0] acc_addr;
  logic [SET_W-1:0] acc_set, nset;
  logic [AW-1:0] tag1, ntag;

  // lookup unit
  row_t lk_row, lk_out;
  logic [AW-1:0] lk_tag;
  logic lk_refresh;
  logic lk_hit;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [WAY_IDX_W-1:0] hit_way, inv_way, lru_way, victim, tw;
  logic inv_found, do_touch;
  logic [RANK_W-1:0] tr;

  assign sb_eff = (set_bits_r > 4'(SB_MAX)) ? 4'(SB_MAX) : set_bits_r;
  assign ways_eff = (ways_used_r == 4'd0) ? 5'd1 :
                    (({1'b0, ways_used_r}) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) :
                    {1'b0, ways_used_r};
  assign smask = (AW'(1) << sb_eff) - AW'(1);
  assign tag_shift = {1'b0, offset_bits_r} + {1'b0, sb_eff};
  assign acc_addr = AW'(in_data.address);
  assign acc_set = SET_W'((acc_addr >> offset_bits_r) & smask);
  assign nset = SET_W'((naddr_r >> offset_bits_r) & smask);
  assign tag1 = addr_r >> tag_shift;
  assign ntag = naddr_r >> tag_shift;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_en[i] = 5'(i) < ways_eff;
    end
  end

  // second lookup forwards the row just written when both blocks share a set
  always_comb begin
    if (state_r == ST_LK2) begin
      lk_row = (nset == set_r) ? wb_row_r : rdata_r;
      lk_tag = ntag;
      lk_refresh = 1'b0;
    end else begin
      lk_row = rdata_r;
      lk_tag = tag1;
      lk_refresh = 1'b1;
    end
  end

  always_comb begin
    hit_vec = '0;
    hit_way = '0;
    inv_way = '0;
    inv_found = 1'b0;
    lru_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i] = way_en[i] && lk_row.valid[i] && (lk_row.tag[i] == lk_tag);
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_IDX_W'(i);
      end
      if (way_en[i] && !lk_row.valid[i]) begin
        inv_way = WAY_IDX_W'(i);
        inv_found = 1'b1;
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (way_en[i] && (lk_row.rank[i] >= lk_row.rank[lru_way])) begin
        lru_way = WAY_IDX_W'(i);
      end
    end
    lk_hit = |hit_vec;
    victim = inv_found ? inv_way : lru_way;
    tw = lk_hit ? hit_way : victim;
    tr = lk_hit ? lk_row.rank[hit_way] : RANK_MAX;
    do_touch = lk_hit ? lk_refresh : 1'b1;

    lk_out = lk_row;
    if (!lk_hit) begin
      lk_out.valid[victim] = 1'b1;
      lk_out.tag[victim] = lk_tag;
    end
    if (do_touch) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if ((WAY_IDX_W'(i) != tw) && way_en[i] && lk_row.valid[i] &&
            (lk_row.rank[i] < tr) && (lk_row.rank[i] < RANK_MAX)) begin
          lk_out.rank[i] = lk_row.rank[i] + RANK_W'(1);
        end
      end
      lk_out.rank[tw] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    out_valid_nxt = 1'b0;
    hits_nxt = hits_r;
    misses_nxt = misses_r;
    reads_nxt = reads_r;
    writes_nxt = writes_r;
    was_hit_nxt = was_hit_r;
    pf_fill_nxt = pf_fill_r;
    rd_en = 1'b0;
    rd_addr = acc_set;
    wr_en = 1'b0;
    wr_addr = set_r;
    wr_row = lk_out;
    case (state_r)
      ST_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_row = '0;
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rd_en = 1'b1;
          state_nxt = ST_LK1;
        end
      end
      ST_LK1: begin
        wr_en = 1'b1;
        was_hit_nxt = lk_hit;
        pf_fill_nxt = 1'b0;
        if (lk_hit) begin
          hits_nxt = (hits_r == CNT_MAX) ? hits_r : hits_r + CW'(1);
        end else begin
          misses_nxt = (misses_r == CNT_MAX) ? misses_r : misses_r + CW'(1);
          reads_nxt = (reads_r == CNT_MAX) ? reads_r : reads_r + CW'(1);
        end
        if (op_r == salcp_pkg::OP_WRITE) begin
          writes_nxt = (writes_r == CNT_MAX) ? writes_r : writes_r + CW'(1);
        end
        if (!lk_hit && prefetch_on_r) begin
          rd_en = 1'b1;
          rd_addr = nset;
          state_nxt = ST_LK2;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LK2: begin
        wr_en = 1'b1;
        wr_addr = nset;
        pf_fill_nxt = !lk_hit;
        if (!lk_hit) begin
          reads_nxt = (reads_r == CNT_MAX) ? reads_r : reads_r + CW'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
      hits_r <= '0;
      misses_r <= '0;
      reads_r <= '0;
      writes_r <= '0;
      offset_bits_r <= salcp_pkg::RST_OFFSET_BITS;
      set_bits_r <= salcp_pkg::RST_SET_BITS;
      ways_used_r <= salcp_pkg::RST_WAYS_USED;
      prefetch_on_r <= salcp_pkg::RST_PREFETCH_ON;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hits_r <= hits_nxt;
      misses_r <= misses_nxt;
      reads_r <= reads_nxt;
      writes_r <= writes_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          salcp_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_data[3:0];
          salcp_pkg::REG_SET_BITS: set_bits_r <= cfg_data[3:0];
          salcp_pkg::REG_WAYS_USED: ways_used_r <= cfg_data[3:0];
          salcp_pkg::REG_PREFETCH_ON: prefetch_on_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    was_hit_r <= was_hit_nxt;
    pf_fill_r <= pf_fill_nxt;
    if (state_r == ST_IDLE && start) begin
      op_r <= in_data.op;
      addr_r <= acc_addr;
      naddr_r <= acc_addr + (AW'(1) << offset_bits_r);
      set_r <= acc_set;
    end
    if (state_r == ST_LK1) begin
      wb_row_r <= lk_out;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data.was_hit = was_hit_r;
  assign out_data.prefetch_filled = pf_fill_r;
  assign out_data.hit_total = hits_r;
  assign out_data.miss_total = misses_r;
  assign out_data.read_total = reads_r;
  assign out_data.write_total = writes_r;

  `SALCP_ASSERT_IMPLY(a_pf_only_on_miss, out_valid, !(out_data.was_hit && out_data.prefetch_filled), "prefetch fill reported on a hit")
  `SALCP_ASSERT_NEXT(a_accept_no_result, start && !busy, busy && !out_valid, "result or idle right after a transfer")
  `SALCP_ASSERT_IMPLY(a_results_spaced, out_valid, !$past(out_valid), "results in adjacent cycles")
  `SALCP_ASSERT_IMPLY(a_hits_saturate, $past(rst_n) && (hits_r != $past(hits_r)), (hits_r == $past(hits_r) + 32'd1) && (hits_r != 32'd0), "hit total stepped wrongly")

endmodule

`default_nettype wire
